@@ sv/gncl_pkg.sv @@
// Shared types and constants for the nonuniform grid cell locator.
// No dependencies; every other file imports this package.
package gncl_pkg;

   // Widths fixed by the item and register formats.
   localparam int POS_W    = 32;
   localparam int SLOT_W   = 6;
   localparam int TOL_W    = 16;
   localparam int COUNT_W  = 7;
   localparam int CELL_W   = 8;
   // Offsets span the full 33-bit difference plus one bit of margin.
   localparam int OFS_W    = 34;
   // Cell index width that covers the largest supported grid.
   localparam int IDX_W    = 11;
   localparam int PADDR_W  = 4;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_RANGE_START = 2'd0;
   localparam logic [1:0] REG_CELL_COUNT  = 2'd1;
   localparam logic [1:0] REG_TOLERANCE   = 2'd2;

   // Opcode of an input word.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOCATE = 1'b1;

   // How the local coordinate of a result is formed.
   typedef enum logic [1:0] {
      COORD_ZERO,
      COORD_ONE,
      COORD_DIV
   } coord_mode_type;

   // Configuration register values.
   typedef struct packed {
      logic signed [POS_W-1:0] range_start;
      logic [COUNT_W-1:0]      cell_count;
      logic [TOL_W-1:0]        tolerance;
   } cfg_type;

   // One slot of the walk pipeline.
   typedef struct packed {
      logic                    valid;
      logic                    is_load;
      logic [SLOT_W-1:0]       slot;
      logic [POS_W-1:0]        width_value;
      logic signed [OFS_W-1:0] offset;
      logic                    below;
      logic                    done;
      logic [IDX_W-1:0]        cell_idx;
      logic [POS_W-1:0]        sel_width;
   } walk_type;

   // One slot of the divider pipeline, without the quotient bits.
   typedef struct packed {
      logic                    valid;
      logic                    is_result;
      logic [CELL_W-1:0]       cell_idx;
      logic                    in_range;
      coord_mode_type          mode;
      logic [POS_W:0]          rem;
      logic [POS_W-1:0]        divisor;
   } div_type;

endpackage

@@ sv/gncl_req_if.sv @@
// Input channel of the grid cell locator: valid, ready and one input word.
// Depends on gncl_pkg for field widths.
interface gncl_req_if
   import gncl_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic [SLOT_W-1:0]       cell_slot;
   logic [POS_W-1:0]        width_value;
   logic signed [POS_W-1:0] position;

   modport source (output valid, opcode, cell_slot, width_value, position, input ready);
   modport sink (input valid, opcode, cell_slot, width_value, position, output ready);
endinterface

@@ sv/gncl_rsp_if.sv @@
// Result channel of the grid cell locator: valid, ready and one result word.
// Depends on gncl_pkg for field widths.
interface gncl_rsp_if
   import gncl_pkg::*;
#(
   parameter int COORD_W = 17
) ();
   logic                     valid;
   logic                     ready;
   logic signed [CELL_W-1:0] cell_res;
   logic [COORD_W-1:0]       local_coord;
   logic                     inside_res;

   modport source (output valid, cell_res, local_coord, inside_res, input ready);
   modport sink (input valid, cell_res, local_coord, inside_res, output ready);
endinterface

@@ sv/gncl_csr.sv @@
// APB-style configuration registers of the grid cell locator.
// Depends on gncl_pkg for register indexes and the cfg_type struct.
module gncl_csr
   import gncl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output cfg_type            cfg
);
   logic signed [POS_W-1:0] range_start_ff;
   logic [COUNT_W-1:0]      cell_count_ff;
   logic [TOL_W-1:0]        tolerance_ff;
   logic                    wr_en;
   logic [1:0]              reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // Register writes at the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_start_ff <= '0;
         cell_count_ff  <= COUNT_W'(1);
         tolerance_ff   <= '0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_RANGE_START: range_start_ff <= csr_pwdata;
            REG_CELL_COUNT:  cell_count_ff  <= csr_pwdata[COUNT_W-1:0];
            REG_TOLERANCE:   tolerance_ff   <= csr_pwdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      case (reg_idx)
         REG_RANGE_START: csr_prdata = range_start_ff;
         REG_CELL_COUNT:  csr_prdata = {{(32-COUNT_W){1'b0}}, cell_count_ff};
         REG_TOLERANCE:   csr_prdata = {{(32-TOL_W){1'b0}}, tolerance_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.range_start = range_start_ff;
   assign cfg.cell_count  = cell_count_ff;
   assign cfg.tolerance   = tolerance_ff;
endmodule

@@ sv/gncl_walk.sv @@
// One cell of the walk pipeline: holds that cell's width and tests one word.
// Depends on gncl_pkg for walk_type and widths.
module gncl_walk
   import gncl_pkg::*;
#(
   parameter int CELL_IDX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic [IDX_W-1:0] n_cells,
   input  logic [TOL_W-1:0] tolerance,
   input  walk_type         stage_in,
   output walk_type         stage_out
);
   localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
   localparam bit               WRITABLE = CELL_IDX < (1 << SLOT_W);

   logic [POS_W-1:0]        width_ff;
   walk_type                stage_ff;
   walk_type                stage_in_next;
   logic signed [OFS_W-1:0] limit;
   logic                    hit_load;

   assign hit_load = WRITABLE && stage_in.valid && stage_in.is_load &&
                     (stage_in.slot == SLOT_W'(CELL_IDX));

   // The word stops here when its offset falls short of this width less the tolerance.
   assign limit = $signed({2'b00, width_ff}) - $signed({{(OFS_W-TOL_W){1'b0}}, tolerance});

   always_comb begin
      stage_in_next = stage_in;
      if (!stage_in.is_load && !stage_in.below && !stage_in.done &&
          (MY_IDX < n_cells)) begin
         if (stage_in.offset < limit) begin
            stage_in_next.done      = 1'b1;
            stage_in_next.cell_idx  = MY_IDX;
            stage_in_next.sel_width = width_ff;
         end else begin
            stage_in_next.offset = stage_in.offset - $signed({2'b00, width_ff});
         end
      end
   end

   // Width of this cell; a load writes it as the load passes, keeping order.
   always_ff @(posedge clock) begin
      if (enable && hit_load) begin
         width_ff <= stage_in.width_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in_next;
      end
   end

   assign stage_out = stage_ff;
endmodule

@@ sv/gncl_div.sv @@
// Pipelined restoring divider: one quotient bit per stage for local_coord.
// Depends on gncl_pkg for div_type and coord_mode_type.
module gncl_div
   import gncl_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  div_type                  div_in,
   output logic                     out_valid,
   output logic signed [CELL_W-1:0] out_cell,
   output logic [FRAC_BITS:0]       out_coord,
   output logic                     out_inside
);
   div_type              st_ff [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_ff  [FRAC_BITS];
   div_type              st_prev [FRAC_BITS];
   logic [FRAC_BITS-1:0] q_prev  [FRAC_BITS];

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
      logic [POS_W+1:0] rem_sh;
      logic [POS_W+1:0] rem_sub;
      logic             take;
      div_type          st_next;

      if (k == 0) begin : g_first
         assign st_prev[k] = div_in;
         assign q_prev[k]  = '0;
      end else begin : g_next
         assign st_prev[k] = st_ff[k-1];
         assign q_prev[k]  = q_ff[k-1];
      end

      // Shift the remainder and subtract the divisor when it fits.
      assign rem_sh  = {st_prev[k].rem, 1'b0};
      assign rem_sub = rem_sh - {2'b00, st_prev[k].divisor};
      assign take    = rem_sh >= {2'b00, st_prev[k].divisor};

      always_comb begin
         st_next     = st_prev[k];
         st_next.rem = take ? rem_sub[POS_W:0] : rem_sh[POS_W:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k].valid <= 1'b0;
         end else if (enable) begin
            st_ff[k] <= st_next;
            q_ff[k]  <= {q_prev[k][FRAC_BITS-2:0], take};
         end
      end
   end

   // Pick the coordinate by mode: the special cases or the quotient.
   always_comb begin
      case (st_ff[FRAC_BITS-1].mode)
         COORD_ONE: out_coord = (FRAC_BITS+1)'(1) << FRAC_BITS;
         COORD_DIV: out_coord = {1'b0, q_ff[FRAC_BITS-1]};
         default:   out_coord = '0;
      endcase
   end

   assign out_valid  = st_ff[FRAC_BITS-1].valid && st_ff[FRAC_BITS-1].is_result;
   assign out_cell   = st_ff[FRAC_BITS-1].cell_idx;
   assign out_inside = st_ff[FRAC_BITS-1].in_range;
endmodule

@@ sv/nonuniform_grid_cell_locator_unit.sv @@
// Nonuniform grid cell locator: top level with channels and register port.
// Depends on gncl_pkg, gncl_req_if, gncl_rsp_if, gncl_csr, gncl_walk, gncl_div.
//
// Usage: a load word (opcode 0) writes one cell width; a locate word
// (opcode 1) returns one result word with the cell index, the local
// coordinate in Q1.FRAC_BITS and an inside flag. Loads return nothing.
// Registers range_start, cell_count and tolerance sit at byte addresses
// 0, 4 and 8; the user must write them only while no word is in flight,
// as the block itself does not enforce it. Throughput: one word per cycle
// while the receiver does not stall. A locate passes one stage for the
// start subtraction, one walk stage per cell, one for classification and
// one divider stage per quotient bit. Each cell's width lives in its own
// walk stage, and a load writes it as it passes, so words stay in order.
// Reset clears the valid bits and restores the registers; widths are
// undefined until loaded. When the receiver stalls with a result waiting,
// the whole pipeline holds and req_chan.ready drops; nothing is lost.
module nonuniform_grid_cell_locator_unit
   import gncl_pkg::*;
#(
   parameter int MAX_CELLS = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   gncl_req_if.sink           req_chan,
   gncl_rsp_if.source         rsp_chan,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [PADDR_W-1:0] csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   localparam logic [IDX_W-1:0] MAX_N = IDX_W'(MAX_CELLS);

   cfg_type                 cfg;
   logic                    enable;
   logic [IDX_W-1:0]        n_cells;
   walk_type                walk_in;
   walk_type                walk_ff;
   walk_type                chain [MAX_CELLS+1];
   walk_type                last;
   div_type                 cls_in;
   div_type                 cls_ff;
   logic signed [OFS_W-1:0] tol_s;
   logic                    rsp_valid;

   gncl_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   // The pipeline moves whenever the result register is free or taken.
   assign enable         = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = enable;

   // Cell count in use, saturated to 1 .. MAX_CELLS.
   always_comb begin
      if (cfg.cell_count == '0) begin
         n_cells = IDX_W'(1);
      end else if (IDX_W'(cfg.cell_count) > MAX_N) begin
         n_cells = MAX_N;
      end else begin
         n_cells = IDX_W'(cfg.cell_count);
      end
   end

   assign tol_s = $signed({{(OFS_W-TOL_W){1'b0}}, cfg.tolerance});

   // Entry stage: subtract the grid start and flag positions below it.
   always_comb begin
      walk_in             = '0;
      walk_in.valid       = req_chan.valid;
      walk_in.is_load     = (req_chan.opcode == OP_LOAD);
      walk_in.slot        = req_chan.cell_slot;
      walk_in.width_value = req_chan.width_value;
      walk_in.offset      = OFS_W'(req_chan.position) - OFS_W'(cfg.range_start);
      walk_in.below       = walk_in.offset < -tol_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff.valid <= 1'b0;
      end else if (enable) begin
         walk_ff <= walk_in;
      end
   end

   // One walk stage per cell.
   assign chain[0] = walk_ff;
   for (genvar c = 0; c < MAX_CELLS; c++) begin : g_walk
      gncl_walk #(.CELL_IDX(c)) u_walk (
         .clock, .reset, .enable, .n_cells, .tolerance(cfg.tolerance),
         .stage_in(chain[c]), .stage_out(chain[c+1])
      );
   end
   assign last = chain[MAX_CELLS];

   // Classification: below, at the end, beyond the end, or inside a cell.
   always_comb begin
      cls_in           = '0;
      cls_in.valid     = last.valid;
      cls_in.is_result = !last.is_load;
      cls_in.divisor   = last.sel_width;
      cls_in.mode      = COORD_ZERO;
      if (last.below) begin
         cls_in.cell_idx = '1;
      end else if (!last.done) begin
         if ((last.offset <= tol_s) && (last.offset >= -tol_s)) begin
            cls_in.cell_idx = CELL_W'(n_cells - IDX_W'(1));
            cls_in.mode     = COORD_ONE;
            cls_in.in_range = 1'b1;
         end else begin
            cls_in.cell_idx = CELL_W'(n_cells);
         end
      end else begin
         cls_in.cell_idx = CELL_W'(last.cell_idx);
         cls_in.in_range = 1'b1;
         if ((last.offset > 0) && (last.sel_width != '0)) begin
            cls_in.mode = COORD_DIV;
            cls_in.rem  = last.offset[POS_W:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff.valid <= 1'b0;
      end else if (enable) begin
         cls_ff <= cls_in;
      end
   end

   gncl_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock, .reset, .enable, .div_in(cls_ff),
      .out_valid(rsp_valid), .out_cell(rsp_chan.cell_res),
      .out_coord(rsp_chan.local_coord), .out_inside(rsp_chan.inside_res)
   );

   assign rsp_chan.valid = rsp_valid;
endmodule
